// ----- hw/rtl/view_depth_index_sorter_unit_assert.svh -----
// Assertion macros for the view depth index sorter.
// Plain text only; included by the top level after its package references.
`ifndef VIEW_DEPTH_INDEX_SORTER_UNIT_ASSERT_SVH
`define VIEW_DEPTH_INDEX_SORTER_UNIT_ASSERT_SVH

// cond_a holding at an edge implies cond_c at the same edge
`define VDIS_ASSERT_IMPL(label, ck, rn, cond_a, cond_c) \
	label: assert property (@(posedge ck) disable iff (!rn) (cond_a) |-> (cond_c)) \
		else $error("sorter check failed");

// cond_a holding at an edge implies cond_c at the next edge
`define VDIS_ASSERT_NEXT(label, ck, rn, cond_a, cond_c) \
	label: assert property (@(posedge ck) disable iff (!rn) (cond_a) |=> (cond_c)) \
		else $error("sorter check failed");

`endif

// ----- hw/rtl/vdis_pkg.sv -----
// Shared constants, payload types and helpers of the view depth index sorter.
// No dependencies; every RTL module refers to it by scoped names.
package vdis_pkg;

	localparam int MAX_OBJECTS = 64;
	localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
	localparam int COORD_W = 16;
	localparam int PROD_W = 2 * COORD_W;
	localparam int KEY_W = 34;
	localparam int IDX_W = 6;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = QPTR_W + 1;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_BACK_TO_FRONT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_X = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_Y = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_Z = CFG_IDX_W'(3);

	localparam logic BACK_TO_FRONT_RST = 1'b1;
	localparam logic [COORD_W-1:0] VIEW_DIR_X_RST = 16'h0000;
	localparam logic [COORD_W-1:0] VIEW_DIR_Y_RST = 16'h0000;
	localparam logic [COORD_W-1:0] VIEW_DIR_Z_RST = 16'hFF00;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic last_object;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] object_index;
		logic last_index;
		logic overflow;
	} out_item_t;

	// one classified request between front and back
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [IDX_W-1:0] idx;
		logic store;
		logic last;
		logic desc;
	} q_entry_t;

	typedef struct packed {
		logic valid;
		q_entry_t entry;
	} q_wr_t;

	typedef struct packed {
		logic emitting;
		logic [CNT_W-1:0] count;
	} back_status_t;

	// arrival index wraps modulo the index field
	function automatic logic [IDX_W-1:0] to_idx(input logic [CNT_W-1:0] c);
		logic [CNT_W+IDX_W-1:0] w;
		w = {{IDX_W{1'b0}}, c};
		return w[IDX_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/view_depth_index_sorter_unit.sv -----
// Top level of the view depth index sorter: front, request queue and back.
// Depends on vdis_pkg, vdis_front, vdis_queue, vdis_back and the assert header.
//
// channel   | handshake              | payload
// ----------+------------------------+------------------------------
// items     | push / full            | in_item (vdis_pkg::in_item_t)
// results   | pop / empty            | result (vdis_pkg::out_item_t)
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Items enter at one per cycle unless full; the depth key is multiplied in one
// stage and queued, and the back inserts one key per cycle into its sorted
// cell rows while loading. After the last item of a set, its n results leave
// at one per cycle from the result register while pop keeps up.
// Reset clears counts, the queue and the result register and restores the
// configuration; the cell rows need no clearing. Front and back stall apart.
module view_depth_index_sorter_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  vdis_pkg::in_item_t in_item,
	output logic empty,
	input  logic pop,
	output vdis_pkg::out_item_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [vdis_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vdis_pkg::CFG_DATA_W-1:0] cfg_data
);

	`include "view_depth_index_sorter_unit_assert.svh"

	vdis_pkg::q_wr_t q_wr;
	vdis_pkg::q_entry_t q_head;
	logic q_empty;
	logic q_rd;
	logic [vdis_pkg::QLVL_W-1:0] q_level;
	vdis_pkg::back_status_t back_st;

	vdis_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.in_item(in_item),
		.full(full),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg_ready(cfg_ready),
		.q_level(q_level),
		.q_wr(q_wr)
	);

	vdis_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(q_wr),
		.rd(q_rd),
		.head(q_head),
		.q_empty(q_empty),
		.level(q_level)
	);

	vdis_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_head(q_head),
		.q_empty(q_empty),
		.q_rd(q_rd),
		.pop(pop),
		.empty(empty),
		.result(result),
		.status(back_st)
	);

	`VDIS_ASSERT_IMPL(a_emit_has_entries, clk, arst_n, back_st.emitting, back_st.count != '0)
	`VDIS_ASSERT_IMPL(a_count_bounded, clk, arst_n, 1'b1,
		back_st.count <= vdis_pkg::CNT_W'(vdis_pkg::MAX_OBJECTS))
	`VDIS_ASSERT_IMPL(a_idle_queue_takes, clk, arst_n, q_level == '0, !full)
	`VDIS_ASSERT_NEXT(a_final_emit_reloads, clk, arst_n,
		back_st.emitting && (back_st.count == vdis_pkg::CNT_W'(1)) && (empty || pop),
		!back_st.emitting)

endmodule

// ----- hw/rtl/vdis_queue.sv -----
// Short request queue between the front and the back of the sorter.
// Depends on vdis_pkg for the entry type and depth.
module vdis_queue (
	input  logic clk,
	input  logic arst_n,
	input  vdis_pkg::q_wr_t wr,
	input  logic rd,
	output vdis_pkg::q_entry_t head,
	output logic q_empty,
	output logic [vdis_pkg::QLVL_W-1:0] level
);

	vdis_pkg::q_entry_t mem_q [vdis_pkg::QDEPTH];
	logic [vdis_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [vdis_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [vdis_pkg::QLVL_W-1:0] level_q;
	logic do_rd;

	assign q_empty = (level_q == '0);
	assign do_rd = rd && !q_empty;
	assign head = mem_q[rd_ptr_q];
	assign level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (wr.valid) begin
				wr_ptr_q <= wr_ptr_q + vdis_pkg::QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + vdis_pkg::QPTR_W'(1);
			end
			if (wr.valid && !do_rd) begin
				level_q <= level_q + vdis_pkg::QLVL_W'(1);
			end else if (!wr.valid && do_rd) begin
				level_q <= level_q - vdis_pkg::QLVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.valid) begin
			mem_q[wr_ptr_q] <= wr.entry;
		end
	end

endmodule

// ----- hw/rtl/vdis_front.sv -----
// Front of the sorter: configuration registers, item intake, depth key and
// store/drop classification. Depends on vdis_pkg; feeds vdis_queue.
module vdis_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  vdis_pkg::in_item_t in_item,
	output logic full,
	input  logic cfg_valid,
	input  logic [vdis_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vdis_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic cfg_ready,
	input  logic [vdis_pkg::QLVL_W-1:0] q_level,
	output vdis_pkg::q_wr_t q_wr
);

	logic btf_q;
	logic signed [vdis_pkg::COORD_W-1:0] vdx_q;
	logic signed [vdis_pkg::COORD_W-1:0] vdy_q;
	logic signed [vdis_pkg::COORD_W-1:0] vdz_q;
	logic [vdis_pkg::CNT_W-1:0] count_q;

	logic valid_s1;
	logic signed [vdis_pkg::PROD_W-1:0] px_s1;
	logic signed [vdis_pkg::PROD_W-1:0] py_s1;
	logic signed [vdis_pkg::PROD_W-1:0] pz_s1;
	logic [vdis_pkg::IDX_W-1:0] idx_s1;
	logic store_s1;
	logic last_s1;
	logic desc_s1;

	logic accept;
	logic store;
	logic [vdis_pkg::QLVL_W:0] reserved;

	assign cfg_ready = 1'b1;

	// count the slot of the request still in the multiply stage
	assign reserved = {1'b0, q_level} + (vdis_pkg::QLVL_W + 1)'(valid_s1);
	assign full = (reserved >= (vdis_pkg::QLVL_W + 1)'(vdis_pkg::QDEPTH));
	assign accept = push && !full;
	assign store = (count_q < vdis_pkg::CNT_W'(vdis_pkg::MAX_OBJECTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btf_q <= vdis_pkg::BACK_TO_FRONT_RST;
			vdx_q <= vdis_pkg::VIEW_DIR_X_RST;
			vdy_q <= vdis_pkg::VIEW_DIR_Y_RST;
			vdz_q <= vdis_pkg::VIEW_DIR_Z_RST;
			count_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					vdis_pkg::CFG_BACK_TO_FRONT: btf_q <= cfg_data[0];
					vdis_pkg::CFG_VIEW_DIR_X: vdx_q <= cfg_data;
					vdis_pkg::CFG_VIEW_DIR_Y: vdy_q <= cfg_data;
					vdis_pkg::CFG_VIEW_DIR_Z: vdz_q <= cfg_data;
					default: ;
				endcase
			end
			valid_s1 <= accept;
			if (accept) begin
				if (in_item.last_object) begin
					count_q <= '0;
				end else if (store) begin
					count_q <= count_q + vdis_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= $signed(in_item.center_x) * vdx_q;
			py_s1 <= $signed(in_item.center_y) * vdy_q;
			pz_s1 <= $signed(in_item.center_z) * vdz_q;
			idx_s1 <= vdis_pkg::to_idx(count_q);
			store_s1 <= store;
			last_s1 <= in_item.last_object;
			desc_s1 <= btf_q;
		end
	end

	always_comb begin
		q_wr.valid = valid_s1;
		q_wr.entry.key = vdis_pkg::KEY_W'(px_s1) + vdis_pkg::KEY_W'(py_s1)
			+ vdis_pkg::KEY_W'(pz_s1);
		q_wr.entry.idx = idx_s1;
		q_wr.entry.store = store_s1;
		q_wr.entry.last = last_s1;
		q_wr.entry.desc = desc_s1;
	end

endmodule

// ----- hw/rtl/vdis_back.sv -----
// Back of the sorter: two insertion-sorted cell rows (ascending and
// descending, both stable) and the result emitter. Depends on vdis_pkg.
module vdis_back (
	input  logic clk,
	input  logic arst_n,
	input  vdis_pkg::q_entry_t q_head,
	input  logic q_empty,
	output logic q_rd,
	input  logic pop,
	output logic empty,
	output vdis_pkg::out_item_t result,
	output vdis_pkg::back_status_t status
);

	typedef enum logic {ST_LOAD, ST_EMIT} state_t;

	typedef struct packed {
		logic signed [vdis_pkg::KEY_W-1:0] key;
		logic [vdis_pkg::IDX_W-1:0] idx;
	} cell_t;

	localparam int N = vdis_pkg::MAX_OBJECTS;

	state_t state_q;
	logic [vdis_pkg::CNT_W-1:0] count_q;
	logic ovf_q;
	logic desc_q;
	logic out_valid_q;
	vdis_pkg::out_item_t out_q;

	cell_t asc_row [N];
	cell_t dsc_row [N];
	cell_t asc_dn [N];
	cell_t dsc_dn [N];
	cell_t asc_up [N];
	cell_t dsc_up [N];
	logic [N-1:0] keep_asc;
	logic [N-1:0] keep_dsc;
	logic [N-1:0] keep_prev_asc;
	logic [N-1:0] keep_prev_dsc;

	cell_t new_cell;
	cell_t head_cell;
	logic ins;
	logic emit_go;

	assign q_rd = (state_q == ST_LOAD) && !q_empty;
	assign ins = q_rd && q_head.store;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || pop);
	assign new_cell = '{key: q_head.key, idx: q_head.idx};
	assign head_cell = desc_q ? dsc_row[0] : asc_row[0];

	assign empty = !out_valid_q;
	assign result = out_q;
	assign status.emitting = (state_q == ST_EMIT);
	assign status.count = count_q;

	// a cell keeps its entry when it precedes or ties with the new key
	always_comb begin
		for (int i = 0; i < N; i++) begin
			keep_asc[i] = (vdis_pkg::CNT_W'(i) < count_q)
				&& ($signed(asc_row[i].key) <= $signed(q_head.key));
			keep_dsc[i] = (vdis_pkg::CNT_W'(i) < count_q)
				&& ($signed(dsc_row[i].key) >= $signed(q_head.key));
		end
		keep_prev_asc = {keep_asc[N-2:0], 1'b1};
		keep_prev_dsc = {keep_dsc[N-2:0], 1'b1};
	end

	// neighbor views: dn = cell below (insertion shift), up = cell above (emit shift)
	always_comb begin
		asc_dn[0] = new_cell;
		dsc_dn[0] = new_cell;
		for (int i = 1; i < N; i++) begin
			asc_dn[i] = asc_row[i-1];
			dsc_dn[i] = dsc_row[i-1];
		end
		for (int i = 0; i < N - 1; i++) begin
			asc_up[i] = asc_row[i+1];
			dsc_up[i] = dsc_row[i+1];
		end
		asc_up[N-1] = asc_row[N-1];
		dsc_up[N-1] = dsc_row[N-1];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			if (ins) begin
				if (!keep_asc[i]) begin
					asc_row[i] <= keep_prev_asc[i] ? new_cell : asc_dn[i];
				end
				if (!keep_dsc[i]) begin
					dsc_row[i] <= keep_prev_dsc[i] ? new_cell : dsc_dn[i];
				end
			end else if (emit_go) begin
				asc_row[i] <= asc_up[i];
				dsc_row[i] <= dsc_up[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q <= 1'b0;
			desc_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
				out_q.object_index <= head_cell.idx;
				out_q.last_index <= (count_q == vdis_pkg::CNT_W'(1));
				out_q.overflow <= ovf_q;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (ins) begin
						count_q <= count_q + vdis_pkg::CNT_W'(1);
					end
					if (q_rd) begin
						if (q_head.last) begin
							state_q <= ST_EMIT;
							desc_q <= q_head.desc;
						end
						if (!q_head.store) begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						count_q <= count_q - vdis_pkg::CNT_W'(1);
						if (count_q == vdis_pkg::CNT_W'(1)) begin
							state_q <= ST_LOAD;
							ovf_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule
